[rtl/core/pnrf_pkg.sv]
package pnrf_pkg;

   localparam int unsigned WordWidth = 64;

   typedef logic signed [WordWidth-1:0] word_type;

   localparam logic [2:0] StatusFine    = 3'd0;
   localparam logic [2:0] StatusCoarse  = 3'd1;
   localparam logic [2:0] StatusZero    = 3'd2;
   localparam logic [2:0] StatusFlat    = 3'd3;
   localparam logic [2:0] StatusCap     = 3'd4;

   localparam logic ModeLoad  = 1'b0;
   localparam logic ModeStart = 1'b1;

   localparam logic [16:0] TolCoarse = 17'd1000;
   localparam logic [16:0] TolFine   = 17'd100000;

   function automatic word_type sat_add(input word_type a, input word_type b);
      logic signed [WordWidth:0] s;
      s = {a[WordWidth-1], a} + {b[WordWidth-1], b};
      if (s[WordWidth] != s[WordWidth-1]) begin
         sat_add = s[WordWidth] ? {1'b1, {(WordWidth-1){1'b0}}} : {1'b0, {(WordWidth-1){1'b1}}};
      end else begin
         sat_add = s[WordWidth-1:0];
      end
   endfunction

   function automatic word_type sat_sub(input word_type a, input word_type b);
      logic signed [WordWidth:0] s;
      s = {a[WordWidth-1], a} - {b[WordWidth-1], b};
      if (s[WordWidth] != s[WordWidth-1]) begin
         sat_sub = s[WordWidth] ? {1'b1, {(WordWidth-1){1'b0}}} : {1'b0, {(WordWidth-1){1'b1}}};
      end else begin
         sat_sub = s[WordWidth-1:0];
      end
   endfunction

   function automatic logic [WordWidth-1:0] mag(input word_type a);
      mag = a[WordWidth-1] ? (~a + 1'b1) : a;
   endfunction

   // sign and magnitude back to saturated two's complement
   function automatic word_type from_sm(input logic neg, input logic [WordWidth-1:0] m);
      if (neg) begin
         from_sm = m[WordWidth-1] ? {1'b1, {(WordWidth-1){1'b0}}} : (~m + 1'b1);
      end else begin
         from_sm = m[WordWidth-1] ? {1'b0, {(WordWidth-1){1'b1}}} : m;
      end
   endfunction

endpackage

[rtl/core/polynomial_newton_root_finder.sv]
// channel | ports  | direction | contents
// request | req_*  | in        | tdata: coeff_index, coeff_value; tuser: mode
// result  | rsp_*  | out       | tdata: root_value, root_order, iteration_total,
//         |        |           |        root_status, roots_found; tlast: last_root
// a load is taken back to back; a start runs through a shared 32x32
// multiplier and a one-bit-a-cycle divider
// req_tready is low from the start request until its last result is taken
// rsp holds while rsp_tready is low; reset is synchronous and clears the sequencer
module polynomial_newton_root_finder #(
   parameter int unsigned POLY_DEGREE    = 5,
   parameter int unsigned MAX_ITERATIONS = 64,
   parameter int unsigned FRACTION_BITS  = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // coeff_index[2:0], coeff_value[66:3], zeros
   input  logic        req_tuser,   // mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // root_value[63:0], root_order[66:64],
                                    // iteration_total[75:67], root_status[78:76],
                                    // roots_found[81:79], zeros
   output logic        rsp_tlast    // last_root
);
   import pnrf_pkg::*;

   localparam int unsigned CW = $clog2(POLY_DEGREE + 1);
   localparam int unsigned TW = $clog2(MAX_ITERATIONS + 1);
   localparam int unsigned DEPTH = POLY_DEGREE + 1;

   localparam logic [4:0] S_IDLE   = 5'd0;
   localparam logic [4:0] S_COPY   = 5'd1;
   localparam logic [4:0] S_INIT   = 5'd2;
   localparam logic [4:0] S_START  = 5'd3;
   localparam logic [4:0] S_PINIT  = 5'd4;
   localparam logic [4:0] S_ITER   = 5'd5;
   localparam logic [4:0] S_PADD   = 5'd6;
   localparam logic [4:0] S_DINIT  = 5'd7;
   localparam logic [4:0] S_DSCALE = 5'd8;
   localparam logic [4:0] S_DADD   = 5'd9;
   localparam logic [4:0] S_CHECK  = 5'd10;
   localparam logic [4:0] S_NEWX   = 5'd11;
   localparam logic [4:0] S_TEST   = 5'd12;
   localparam logic [4:0] S_TOL    = 5'd13;
   localparam logic [4:0] S_OUT    = 5'd14;
   localparam logic [4:0] S_EMIT   = 5'd15;
   localparam logic [4:0] S_FADD   = 5'd16;
   localparam logic [4:0] S_FWRITE = 5'd17;
   localparam logic [4:0] S_LAST   = 5'd18;
   localparam logic [4:0] S_MLOAD  = 5'd19;
   localparam logic [4:0] S_MUL    = 5'd20;
   localparam logic [4:0] S_MRND   = 5'd21;
   localparam logic [4:0] S_DIV    = 5'd22;

   localparam logic [1:0] R_INIT = 2'd0;
   localparam logic [1:0] R_NEWX = 2'd1;
   localparam logic [1:0] R_LAST = 2'd2;

   word_type loaded_mem [DEPTH];
   word_type work_ff    [DEPTH];

   logic [4:0]       state_ff, ret_ff;
   logic [1:0]       div_ret_ff;
   logic [CW-1:0]    deg_ff, idx_ff, scale_ff;
   logic [8:0]       iter_ff;
   logic [2:0]       roots_ff;
   logic [TW-1:0]    tries_ff;
   word_type         x_ff, acc_ff, f_ff, term_ff, diff_ff, mul_res_ff;

   // shared multiplier: 4 partial products of 32x32 on acc times x
   logic [63:0]      ma_ff, mb_ff;
   logic             mneg_ff;
   logic [127:0]     prod_ff;
   logic [1:0]       mstep_ff;
   logic [31:0]      pa, pb;
   logic [63:0]      pp;

   // shared divider: restoring, one bit a cycle
   logic [63:0]      nh_ff, nl_ff, rem_ff, qh_ff, ql_ff, dvs_ff;
   logic [7:0]       dcnt_ff;
   logic             dneg_ff;
   logic [63:0]      rem_sh;
   logic             dcarry;
   word_type         div_res_ff;

   // tolerance compare
   logic [80:0]      tol_prod;
   logic             fine_ff;

   word_type         out_root_ff;
   logic [2:0]       out_status_ff;
   logic             out_last_ff;

   logic             req_fire;
   logic [CW-1:0]    req_idx;

   assign req_fire   = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {6'd0, roots_ff, out_status_ff, iter_ff,
                        3'(deg_ff), out_root_ff};
   assign req_idx    = CW'(req_tdata[2:0]);

   always_comb begin
      unique case (mstep_ff)
         2'd0: begin pa = ma_ff[31:0];  pb = mb_ff[31:0];  end
         2'd1: begin pa = ma_ff[63:32]; pb = mb_ff[31:0];  end
         2'd2: begin pa = ma_ff[31:0];  pb = mb_ff[63:32]; end
         default: begin pa = ma_ff[63:32]; pb = mb_ff[63:32]; end
      endcase
      pp = pa * pb;
   end

   assign dcarry = rem_ff[63];
   assign rem_sh = {rem_ff[62:0], nh_ff[63]};
   assign tol_prod = mag(diff_ff) * (fine_ff ? TolFine : TolCoarse);

   function automatic word_type round_prod(input logic [127:0] p, input logic neg);
      logic [127:0] r;
      r = p + (128'd1 << (FRACTION_BITS - 1));
      r = r >> FRACTION_BITS;
      round_prod = from_sm(neg, (r[127:64] != 0) ? {64{1'b1}} : r[63:0]);
   endfunction

   always_ff @(posedge clock) begin
      if (req_fire && req_tuser == ModeLoad && req_tdata[2:0] <= 3'(POLY_DEGREE)) begin
         loaded_mem[req_idx] <= req_tdata[66:3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         deg_ff   <= CW'(POLY_DEGREE);
         iter_ff  <= '0;
         roots_ff <= '0;
         x_ff     <= '0;
         mstep_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_fire && req_tuser == ModeStart) begin
                  idx_ff   <= '0;
                  state_ff <= S_COPY;
               end
            end
            S_COPY: begin
               work_ff[idx_ff] <= loaded_mem[idx_ff];
               if (idx_ff == CW'(POLY_DEGREE)) state_ff <= S_INIT;
               else idx_ff <= idx_ff + 1'b1;
            end
            S_INIT: begin
               deg_ff   <= CW'(POLY_DEGREE);
               iter_ff  <= '0;
               roots_ff <= '0;
               nh_ff    <= work_ff[POLY_DEGREE-1];
               dvs_ff   <= work_ff[POLY_DEGREE];
               div_ret_ff <= R_INIT;
               state_ff <= S_DIV;
               dcnt_ff  <= 8'hff;
            end
            // negate the starting quotient
            S_START: begin
               x_ff     <= sat_sub('0, div_res_ff);
               state_ff <= S_PINIT;
            end
            S_PINIT: begin
               tries_ff <= '0;
               state_ff <= S_ITER;
            end
            S_ITER: begin
               acc_ff   <= work_ff[deg_ff];
               idx_ff   <= deg_ff;
               ret_ff   <= S_PADD;
               state_ff <= S_MLOAD;
            end
            S_PADD: begin
               acc_ff <= sat_add(mul_res_ff, work_ff[idx_ff - 1'b1]);
               idx_ff <= idx_ff - 1'b1;
               if (idx_ff == CW'(1)) state_ff <= S_DINIT;
               else state_ff <= S_MLOAD;
            end
            S_DINIT: begin
               f_ff       <= acc_ff;
               mul_res_ff <= '0;
               term_ff    <= '0;
               scale_ff   <= '0;
               idx_ff     <= deg_ff;
               state_ff   <= S_DSCALE;
            end
            // repeated saturating add of the coefficient
            S_DSCALE: begin
               if (scale_ff == idx_ff) begin
                  state_ff <= S_DADD;
               end else begin
                  term_ff  <= sat_add(term_ff, work_ff[idx_ff]);
                  scale_ff <= scale_ff + 1'b1;
               end
            end
            S_DADD: begin
               acc_ff <= sat_add(mul_res_ff, term_ff);
               if (idx_ff == CW'(1)) state_ff <= S_CHECK;
               else begin
                  idx_ff   <= idx_ff - 1'b1;
                  term_ff  <= '0;
                  scale_ff <= '0;
                  ret_ff   <= S_DSCALE;
                  state_ff <= S_MLOAD;
               end
            end
            S_CHECK: begin
               if (acc_ff == '0) begin
                  out_root_ff   <= x_ff;
                  out_status_ff <= StatusFlat;
                  out_last_ff   <= 1'b1;
                  roots_ff      <= roots_ff + 1'b1;
                  state_ff      <= S_OUT;
               end else begin
                  iter_ff <= iter_ff + 1'b1;
                  if (f_ff == '0) begin
                     out_root_ff   <= x_ff;
                     out_status_ff <= StatusZero;
                     out_last_ff   <= 1'b1;
                     roots_ff      <= roots_ff + 1'b1;
                     state_ff      <= S_OUT;
                  end else begin
                     nh_ff      <= f_ff;
                     dvs_ff     <= acc_ff;
                     div_ret_ff <= R_NEWX;
                     dcnt_ff    <= 8'hff;
                     state_ff   <= S_DIV;
                  end
               end
            end
            S_NEWX: begin
               x_ff     <= sat_sub(x_ff, div_res_ff);
               diff_ff  <= sat_sub(sat_sub(x_ff, div_res_ff), x_ff);
               tries_ff <= tries_ff + 1'b1;
               fine_ff  <= 1'b0;
               state_ff <= S_TEST;
            end
            S_TEST: begin
               if (tol_prod[80:64] == '0 && tol_prod[63:0] < mag(x_ff)) begin
                  fine_ff  <= 1'b1;
                  state_ff <= S_TOL;
               end else if (tries_ff == TW'(MAX_ITERATIONS)) begin
                  out_status_ff <= StatusCap;
                  out_root_ff   <= x_ff;
                  out_last_ff   <= 1'b1;
                  roots_ff      <= roots_ff + 1'b1;
                  state_ff      <= S_OUT;
               end else begin
                  state_ff <= S_ITER;
               end
            end
            S_TOL: begin
               out_status_ff <= (tol_prod[80:64] == '0 && tol_prod[63:0] < mag(x_ff))
                                ? StatusFine : StatusCoarse;
               out_root_ff   <= x_ff;
               out_last_ff   <= 1'b0;
               roots_ff      <= roots_ff + 1'b1;
               state_ff      <= S_OUT;
            end
            S_OUT: begin
               if (rsp_tready) begin
                  if (out_last_ff) state_ff <= S_IDLE;
                  else state_ff <= S_EMIT;
               end
            end
            // deflation: tmp[i-1] = a[i] + tmp[i]*x, tmp[i] written once a[i] is used
            S_EMIT: begin
               acc_ff   <= '0;
               idx_ff   <= deg_ff;
               ret_ff   <= S_FADD;
               state_ff <= S_MLOAD;
            end
            S_FADD: begin
               term_ff  <= sat_add(work_ff[idx_ff], mul_res_ff);
               state_ff <= S_FWRITE;
            end
            S_FWRITE: begin
               work_ff[idx_ff] <= acc_ff;
               acc_ff <= term_ff;
               idx_ff <= idx_ff - 1'b1;
               if (idx_ff == CW'(1)) begin
                  work_ff[0] <= term_ff;
                  deg_ff <= deg_ff - 1'b1;
                  if (deg_ff == CW'(2)) begin
                     nh_ff      <= term_ff;
                     dvs_ff     <= acc_ff;
                     div_ret_ff <= R_LAST;
                     dcnt_ff    <= 8'hff;
                     state_ff   <= S_DIV;
                  end else state_ff <= S_PINIT;
               end else state_ff <= S_MLOAD;
            end
            S_LAST: begin
               out_root_ff   <= sat_sub('0, div_res_ff);
               out_status_ff <= StatusFine;
               out_last_ff   <= 1'b1;
               roots_ff      <= roots_ff + 1'b1;
               state_ff      <= S_OUT;
            end
            S_MLOAD: begin
               ma_ff    <= mag(acc_ff);
               mb_ff    <= mag(x_ff);
               mneg_ff  <= acc_ff[63] != x_ff[63];
               mstep_ff <= 2'd0;
               state_ff <= S_MUL;
            end
            S_MUL: begin
               unique case (mstep_ff)
                  2'd0: prod_ff <= {64'd0, pp};
                  2'd1: prod_ff <= prod_ff + {32'd0, pp, 32'd0};
                  2'd2: prod_ff <= prod_ff + {32'd0, pp, 32'd0};
                  default: prod_ff <= prod_ff + {pp, 64'd0};
               endcase
               mstep_ff <= mstep_ff + 1'b1;
               if (mstep_ff == 2'd3) state_ff <= S_MRND;
            end
            S_MRND: begin
               mul_res_ff <= round_prod(prod_ff, mneg_ff);
               state_ff   <= ret_ff;
            end
            S_DIV: begin
               if (dcnt_ff == 8'hff) begin
                  dneg_ff <= nh_ff[63] != dvs_ff[63];
                  if (dvs_ff == '0) begin
                     div_res_ff <= (nh_ff == '0) ? '0 :
                        (nh_ff[63] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}});
                     dcnt_ff <= 8'd129;
                  end else begin
                     nl_ff   <= mag(nh_ff) << FRACTION_BITS;
                     nh_ff   <= mag(nh_ff) >> (64 - FRACTION_BITS);
                     dvs_ff  <= mag(dvs_ff);
                     rem_ff  <= '0;
                     qh_ff   <= '0;
                     ql_ff   <= '0;
                     dcnt_ff <= 8'd0;
                  end
               end else if (dcnt_ff < 8'd128) begin
                  nh_ff <= {nh_ff[62:0], nl_ff[63]};
                  nl_ff <= {nl_ff[62:0], 1'b0};
                  qh_ff <= {qh_ff[62:0], ql_ff[63]};
                  if (dcarry || rem_sh >= dvs_ff) begin
                     rem_ff <= rem_sh - dvs_ff;
                     ql_ff  <= {ql_ff[62:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     ql_ff  <= {ql_ff[62:0], 1'b0};
                  end
                  dcnt_ff <= dcnt_ff + 1'b1;
               end else begin
                  if (dcnt_ff == 8'd128) begin
                     div_res_ff <= from_sm(dneg_ff,
                        (qh_ff != '0 || (rem_ff >= dvs_ff - rem_ff && ql_ff == '1))
                        ? {64{1'b1}}
                        : ql_ff + 64'(rem_ff >= dvs_ff - rem_ff));
                  end
                  unique case (div_ret_ff)
                     R_INIT:  state_ff <= S_START;
                     R_NEWX:  state_ff <= S_NEWX;
                     default: state_ff <= S_LAST;
                  endcase
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid) else $error("ready while result pending");
   a_roots_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[81:79] != 3'd0)) else $error("zero root count");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("not idle after last result");
`endif

endmodule
